// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the base-alphabet string parser.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ATOI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define ATOI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/atoi_pkg.sv =====
// Shared types, constants and helpers of the base-alphabet string parser.
// No dependencies; every RTL module imports this package.
package atoi_pkg;

    localparam int MAX_DIGITS_DEF = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int COUNT_W       = 5;
    localparam int CHARS_PER_REG = 8;
    localparam int OUT_W         = 32;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHARS_LOW  = 2'd0,
        REG_CHARS_HIGH = 2'd1,
        REG_COUNT      = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_SPACE  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

endpackage

// ===== hw/rtl/atoi_alpha.sv =====
// Alphabet registers of the parser and their registered decode:
// active positions, effective length and validity. Depends on atoi_pkg.
module atoi_alpha #(
    parameter int MAX_DIGITS = atoi_pkg::MAX_DIGITS_DEF,
    parameter int LEN_W      = $clog2(MAX_DIGITS + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [atoi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [atoi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic [MAX_DIGITS-1:0][7:0]       chars,
    output logic [MAX_DIGITS-1:0]            active,
    output logic [LEN_W-1:0]                 len,
    output logic                             base_ok
);
    import atoi_pkg::*;

    logic [MAX_DIGITS-1:0][7:0] chars_reg;
    logic [COUNT_W-1:0]         count_reg;
    logic [MAX_DIGITS-1:0]      active_reg, active_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic                       ok_reg, ok_next;

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_char
        localparam int Lane = g % CHARS_PER_REG;
        localparam cfg_reg_t Sel = (g < CHARS_PER_REG) ? REG_CHARS_LOW : REG_CHARS_HIGH;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                chars_reg[g] <= '0;
            end
            else if (cfg_we && (cfg_index == Sel))
            begin
                chars_reg[g] <= cfg_wdata[Lane*8 +: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we && (cfg_index == REG_COUNT))
        begin
            count_reg <= cfg_wdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        logic [COUNT_W-1:0] n;
        logic               bad;
        n = (count_reg > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS) : count_reg;
        len_next = LEN_W'(n);
        // The alphabet ends at its first zero byte; scan downward so the lowest wins.
        for (int i = MAX_DIGITS - 1; i >= 0; i--)
        begin
            if ((COUNT_W'(i) < n) && (chars_reg[i] == CH_NUL))
            begin
                len_next = LEN_W'(i);
            end
        end
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            active_next[i] = LEN_W'(i) < len_next;
        end
        bad = 1'b0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (active_next[i] && (is_sign(chars_reg[i]) || is_space(chars_reg[i])))
            begin
                bad = 1'b1;
            end
            for (int j = i + 1; j < MAX_DIGITS; j++)
            begin
                if (active_next[j] && (chars_reg[i] == chars_reg[j]))
                begin
                    bad = 1'b1;
                end
            end
        end
        ok_next = (len_next > LEN_W'(1)) && !bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            len_reg    <= '0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            len_reg    <= len_next;
            ok_reg     <= ok_next;
        end
    end

    assign chars   = chars_reg;
    assign active  = active_reg;
    assign len     = len_reg;
    assign base_ok = ok_reg;

endmodule

// ===== hw/rtl/atoi_parse.sv =====
// Parser core: digit match, sign and whitespace handling, multiply-add
// accumulator and the result register. Depends on atoi_pkg.
module atoi_parse #(
    parameter int MAX_DIGITS = atoi_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = atoi_pkg::VALUE_BITS_DEF,
    parameter int LEN_W      = $clog2(MAX_DIGITS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [7:0]                      char_in,
    input  logic                            last,
    input  logic [MAX_DIGITS-1:0][7:0]      chars,
    input  logic [MAX_DIGITS-1:0]           active,
    input  logic [LEN_W-1:0]                len,
    input  logic                            base_ok,
    input  logic                            res_ready,
    output logic                            res_valid,
    output logic [atoi_pkg::OUT_W-1:0]      res_value,
    output logic                            res_ok
);
    import atoi_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIGITS);

    phase_t                  phase_reg, phase_next, phase_upd;
    logic                    neg_reg, neg_next, neg_upd;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next, acc_upd;
    logic                    hit;
    logic [IDX_W-1:0]        idx;
    logic [VALUE_BITS-1:0]   prod;
    logic                    emit;
    logic signed [VALUE_BITS-1:0] result;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]        value_reg;
    logic                    ok_reg;

    always_comb
    begin
        hit = 1'b0;
        idx = '0;
        for (int i = MAX_DIGITS - 1; i >= 0; i--)
        begin
            if (active[i] && (chars[i] == char_in))
            begin
                hit = 1'b1;
                idx = IDX_W'(i);
            end
        end
    end

    assign prod = VALUE_BITS'(acc_reg * VALUE_BITS'(len));
    assign emit = (char_in == CH_NUL) || last;

    always_comb
    begin
        phase_upd = phase_reg;
        neg_upd   = neg_reg;
        acc_upd   = acc_reg;
        if (char_in != CH_NUL)
        begin
            case (phase_reg)
                PH_SPACE:
                begin
                    if (is_space(char_in))
                    begin
                        phase_upd = PH_SPACE;
                    end
                    else if (is_sign(char_in))
                    begin
                        neg_upd   = (char_in == CH_MINUS);
                        phase_upd = PH_DIGITS;
                    end
                    else if (hit)
                    begin
                        acc_upd   = VALUE_BITS'(idx);
                        phase_upd = PH_DIGITS;
                    end
                    else
                    begin
                        phase_upd = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    if (hit)
                    begin
                        acc_upd = prod + VALUE_BITS'(idx);
                    end
                    else
                    begin
                        phase_upd = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    phase_upd = PH_DONE;
                end
                default:
                begin
                    phase_upd = phase_reg;
                end
            endcase
        end

        result = '0;
        if (base_ok)
        begin
            result = neg_upd ? (VALUE_BITS'(0) - acc_upd) : acc_upd;
        end

        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (step)
        begin
            if (emit)
            begin
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                acc_next   = '0;
            end
            else
            begin
                phase_next = phase_upd;
                neg_next   = neg_upd;
                acc_next   = acc_upd;
            end
        end

        if (step && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result is sign-extended or truncated to the output width.
    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            value_reg <= OUT_W'(result);
            ok_reg    <= base_ok;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_value = value_reg;
    assign res_ok    = ok_reg;

endmodule

// ===== hw/rtl/atoi_base_stream_parser.sv =====
// Top level of the base-alphabet string parser: input register, alphabet
// decode and parser core. Depends on atoi_pkg, atoi_alpha, atoi_parse.
//
//   channel  | direction | payload                       | transfer
//   s_axis   | in        | tdata: char_in, tlast: last   | one byte of the string
//   m_axis   | out       | tdata: value, tuser: base_ok  | one result per string
//   cfg      | in        | cfg_index, cfg_wdata          | one register write
//
// One byte is taken every cycle while s_axis_tready is high. The byte that
// ends a string waits in the input register until it advances, and that
// loads the result register, so the result is valid in the cycle after the byte leaves the input register.
// The rate is set by the combinational digit match and multiply-add.
// A stalled result holds the result register; the input register still
// takes one byte, and s_axis_tready drops only when both are full.
// Reset clears the alphabet registers and parser state at once.
module atoi_base_stream_parser #(
    parameter int MAX_DIGITS = atoi_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = atoi_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] char_in
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [atoi_pkg::OUT_W-1:0]       m_axis_tdata,  // [31:0] value
    output logic                             m_axis_tuser,  // [0] base_ok
    input  logic                             cfg_we,
    input  logic [atoi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [atoi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import atoi_pkg::*;

    `include "assert_macros.svh"

    localparam int LEN_W = $clog2(MAX_DIGITS + 1);

    logic                       in_valid_reg, in_valid_next;
    logic [7:0]                 in_char_reg;
    logic                       in_last_reg;
    logic                       advance;
    logic                       s_accept;
    logic [MAX_DIGITS-1:0][7:0] chars;
    logic [MAX_DIGITS-1:0]      active;
    logic [LEN_W-1:0]           len;
    logic                       base_ok;

    assign advance       = in_valid_reg && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    atoi_alpha #(
        .MAX_DIGITS (MAX_DIGITS),
        .LEN_W      (LEN_W)
    ) u_alpha (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .chars     (chars),
        .active    (active),
        .len       (len),
        .base_ok   (base_ok)
    );

    atoi_parse #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS),
        .LEN_W      (LEN_W)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_in   (in_char_reg),
        .last      (in_last_reg),
        .chars     (chars),
        .active    (active),
        .len       (len),
        .base_ok   (base_ok),
        .res_ready (m_axis_tready),
        .res_valid (m_axis_tvalid),
        .res_value (m_axis_tdata),
        .res_ok    (m_axis_tuser)
    );

    // An invalid alphabet must always report zero.
    `ATOI_ASSERT_IMP(a_bad_base_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0,
        "result with invalid alphabet is not zero")
    // A byte marked last that leaves the input register produces a result.
    `ATOI_ASSERT_NXT(a_last_gives_result, advance && in_last_reg, m_axis_tvalid,
        "last byte consumed without a result")
    // A new result only appears when a byte was consumed.
    `ATOI_ASSERT_IMP(a_result_from_step, $rose(m_axis_tvalid), $past(advance),
        "result appeared without a consumed byte")

endmodule
